// ===== design/ogpd_pkg.sv =====
`timescale 1ns / 1ps
package ogpd_pkg;

    localparam int PREFIX_LEN = 19;
    localparam int PKT_LEN_W  = 13;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_SHORT     = 3'd3;
    localparam logic [2:0] ERR_NOT_MONO  = 3'd4;
    localparam logic [2:0] ERR_DURATION  = 3'd5;

    localparam logic [23:0] SYNC_PREFIX  = 24'h4F6767;
    localparam logic [7:0]  SYNC_LAST    = 8'h53;
    localparam logic [63:0] HEAD_MAGIC   = 64'h4F70_7573_4865_6164;
    localparam logic [63:0] TAGS_MAGIC   = 64'h4F70_7573_5461_6773;
    localparam logic [4:0]  HDR_LAST_POS = 5'd22;
    localparam logic [7:0]  LACE_FULL    = 8'd255;
    localparam logic [15:0] RATE_DEFAULT = 16'd48000;
    localparam logic [5:0]  MAX_QUARTERS = 6'd48;  // 120 ms in 2.5 ms units

    typedef struct packed {
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           byte_out;
        logic [PKT_LEN_W-1:0] packet_length;
        logic [6:0]           duration_ms;
        logic [15:0]          rate_hz;
        logic [2:0]           error_code;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic       find;
        logic       win_clr;
        logic       hdr;
        logic       lac;
        logic       load;
        logic       data;
        logic       seg;
        logic       err;
        logic [2:0] err_code;
        logic       push;
    } t_dp_cmd;

    typedef struct packed {
        logic sync_hit;
        logic hdr_last;
        logic ver_bad;
        logic byte_zero;
        logic lac_last;
        logic overflow;
        logic left_one;
        logic rd_zero;
        logic will_mark;
        logic will_err;
        logic pos_next_done;
        logic pend_any;
        logic out_free;
    } t_dp_stat;

    // Frame size in 2.5 ms units for a TOC configuration number.
    function automatic logic [4:0] dur_unit(input logic [4:0] cfg);
        logic [4:0] u;
        if (cfg < 5'd12) begin
            case (cfg[1:0])
                2'd0:    u = 5'd4;
                2'd1:    u = 5'd8;
                2'd2:    u = 5'd16;
                default: u = 5'd24;
            endcase
        end else if (cfg < 5'd16) begin
            u = cfg[0] ? 5'd8 : 5'd4;
        end else begin
            case (cfg[1:0])
                2'd0:    u = 5'd1;
                2'd1:    u = 5'd2;
                2'd2:    u = 5'd4;
                default: u = 5'd8;
            endcase
        end
        return u;
    endfunction

    function automatic t_out_item err_item(input logic [2:0] code);
        t_out_item e;
        e            = '0;
        e.kind       = KIND_ERROR;
        e.error_code = code;
        e.last       = 1'b1;
        return e;
    endfunction

endpackage

// ===== design/ogpd_in_if.sv =====
`timescale 1ns / 1ps
interface ogpd_in_if;
    logic               valid;
    logic               ready;
    ogpd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ogpd_out_if.sv =====
`timescale 1ns / 1ps
interface ogpd_out_if;
    logic                valid;
    logic                ready;
    ogpd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ogpd_datapath.sv =====
`timescale 1ns / 1ps
module ogpd_datapath #(
    parameter int PACKET_BUF_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogpd_pkg::t_in_item  i_item,
    input  ogpd_pkg::t_dp_cmd   i_cmd,
    output ogpd_pkg::t_dp_stat  o_stat,
    output logic                o_res_valid,
    output ogpd_pkg::t_out_item o_res_data,
    input  logic                i_res_ready
);

    localparam int PW = $clog2(PACKET_BUF_BYTES + 1);
    localparam int OW = PW + 1;

    logic [23:0]         r_win;
    logic [4:0]          r_hpos;
    logic [7:0]          r_total;
    logic [8:0]          r_pos;
    logic [7:0]          r_left;
    logic [7:0]          r_len;
    logic [PW-1:0]       r_pkt;
    logic [7:0]          r_prefix [ogpd_pkg::PREFIX_LEN];
    logic [7:0]          r_mem [256];
    logic [7:0]          r_rd;
    logic                r_head;
    logic                r_tags;
    logic [15:0]         r_rate;
    logic [7:0]          r_pbyte;
    logic                r_bpend;
    ogpd_pkg::t_out_item r_mark;
    logic                r_mpend;
    ogpd_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [7:0]          b;
    logic [8:0]          pos_inc;
    logic [63:0]         magic;
    logic                n_ge8;
    logic                n_ge19;
    logic                head_hit;
    logic                tags_hit;
    logic [31:0]         head_rate;
    logic                rate_ok;
    logic [4:0]          unit;
    logic [5:0]          cnt;
    logic                cnt_ok;
    logic [10:0]         quarters;
    logic                dur_ok;
    logic [6:0]          dur;
    ogpd_pkg::t_out_item ev;
    logic                ev_err;
    logic                will_mark;
    logic                out_free;
    ogpd_pkg::t_out_item byte_res;

    assign b       = i_item.byte_in;
    assign pos_inc = r_pos + 9'd1;
    assign magic   = {r_prefix[0], r_prefix[1], r_prefix[2], r_prefix[3],
                      r_prefix[4], r_prefix[5], r_prefix[6], r_prefix[7]};
    assign n_ge8   = r_pkt >= PW'(8);
    assign n_ge19  = r_pkt >= PW'(ogpd_pkg::PREFIX_LEN);
    assign head_hit = !r_head && n_ge8 && (magic == ogpd_pkg::HEAD_MAGIC);
    assign tags_hit = !r_tags && n_ge8 && (magic == ogpd_pkg::TAGS_MAGIC);
    assign head_rate = {r_prefix[15], r_prefix[14], r_prefix[13], r_prefix[12]};
    assign rate_ok  = (head_rate == 32'd8000)  || (head_rate == 32'd12000) ||
                      (head_rate == 32'd16000) || (head_rate == 32'd24000) ||
                      (head_rate == 32'd48000);

    // Duration from the TOC byte, counted in 2.5 ms units.
    assign unit = ogpd_pkg::dur_unit(r_prefix[0][7:3]);
    always_comb begin
        cnt_ok = 1'b1;
        case (r_prefix[0][1:0])
            2'd0: cnt = 6'd1;
            2'd3: begin
                cnt    = r_prefix[1][5:0];
                cnt_ok = r_pkt >= PW'(2);
            end
            default: cnt = 6'd2;
        endcase
    end
    assign quarters = 11'(unit) * 11'(cnt);
    assign dur_ok   = cnt_ok && (cnt != 6'd0) &&
                      (quarters <= 11'(ogpd_pkg::MAX_QUARTERS)) && !quarters[0];
    assign dur      = 7'(quarters[5:1]) * 7'd5;

    always_comb begin
        ev               = '0;
        ev.kind          = ogpd_pkg::KIND_DISCARD;
        ev.packet_length = ogpd_pkg::PKT_LEN_W'(r_pkt);
        ev.last          = 1'b1;
        ev_err           = 1'b0;
        if (head_hit) begin
            if (!n_ge19) begin
                ev     = ogpd_pkg::err_item(ogpd_pkg::ERR_SHORT);
                ev_err = 1'b1;
            end else if (r_prefix[9] != 8'd1) begin
                ev     = ogpd_pkg::err_item(ogpd_pkg::ERR_NOT_MONO);
                ev_err = 1'b1;
            end
        end else if (tags_hit) begin
            ev.kind = ogpd_pkg::KIND_DISCARD;
        end else if (r_head && r_tags) begin
            if (!dur_ok) begin
                ev     = ogpd_pkg::err_item(ogpd_pkg::ERR_DURATION);
                ev_err = 1'b1;
            end else begin
                ev.kind        = ogpd_pkg::KIND_ACCEPT;
                ev.duration_ms = dur;
                ev.rate_hz     = r_rate;
            end
        end
    end

    assign will_mark = (r_len != ogpd_pkg::LACE_FULL) && (r_pkt != '0);
    assign out_free  = !r_out_valid || i_res_ready;

    always_comb begin
        o_stat.sync_hit      = (r_win == ogpd_pkg::SYNC_PREFIX) && (b == ogpd_pkg::SYNC_LAST);
        o_stat.hdr_last      = r_hpos >= ogpd_pkg::HDR_LAST_POS;
        o_stat.ver_bad       = r_total != 8'd0;
        o_stat.byte_zero     = b == 8'd0;
        o_stat.lac_last      = pos_inc >= {1'b0, r_total};
        o_stat.overflow      = (OW'(r_pkt) + OW'(r_left)) > OW'(PACKET_BUF_BYTES);
        o_stat.left_one      = r_left == 8'd1;
        o_stat.rd_zero       = r_rd == 8'd0;
        o_stat.will_mark     = will_mark;
        o_stat.will_err      = will_mark && ev_err;
        o_stat.pos_next_done = pos_inc >= {1'b0, r_total};
        o_stat.pend_any      = r_bpend || r_mpend;
        o_stat.out_free      = out_free;
    end

    always_comb begin
        byte_res          = '0;
        byte_res.kind     = ogpd_pkg::KIND_BYTE;
        byte_res.byte_out = r_pbyte;
        byte_res.last     = !r_mpend;
    end

    // Lacing table, packet prefix and result registers: payload storage, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lac) begin
            r_mem[r_pos[7:0]] <= b;
        end
        r_rd <= r_mem[r_pos[7:0]];
        if (i_cmd.data) begin
            r_pbyte <= b;
            if (r_pkt < PW'(ogpd_pkg::PREFIX_LEN)) begin
                r_prefix[r_pkt[4:0]] <= b;
            end
        end
        if (i_cmd.load) begin
            r_len <= r_rd;
        end
        if (i_cmd.err) begin
            r_mark <= ogpd_pkg::err_item(i_cmd.err_code);
        end else if (i_cmd.seg && will_mark) begin
            r_mark <= ev;
        end
        if (i_cmd.push) begin
            r_out <= r_bpend ? byte_res : r_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_hpos      <= '0;
            r_total     <= '0;
            r_pos       <= '0;
            r_left      <= '0;
            r_pkt       <= '0;
            r_head      <= 1'b0;
            r_tags      <= 1'b0;
            r_rate      <= ogpd_pkg::RATE_DEFAULT;
            r_bpend     <= 1'b0;
            r_mpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.find) begin
                r_win  <= o_stat.sync_hit ? 24'd0 : {r_win[15:0], b};
                r_hpos <= '0;
            end else if (i_cmd.win_clr) begin
                r_win <= '0;
            end

            if (i_cmd.hdr) begin
                if (r_hpos == 5'd0) begin
                    r_total <= b;
                end
                if (o_stat.hdr_last) begin
                    if (!o_stat.ver_bad) begin
                        r_total <= b;
                        r_pos   <= '0;
                        r_hpos  <= '0;
                    end
                end else begin
                    r_hpos <= r_hpos + 5'd1;
                end
            end

            if (i_cmd.lac) begin
                r_pos <= o_stat.lac_last ? 9'd0 : pos_inc;
            end

            if (i_cmd.load) begin
                r_left <= r_rd;
            end

            if (i_cmd.data) begin
                r_bpend <= 1'b1;
                r_pkt   <= r_pkt + PW'(1);
                r_left  <= r_left - 8'd1;
            end

            if (i_cmd.seg) begin
                r_pos <= pos_inc;
                if (r_len != ogpd_pkg::LACE_FULL) begin
                    r_pkt <= '0;
                end
                if (will_mark) begin
                    r_mpend <= 1'b1;
                    if (head_hit) begin
                        r_head <= 1'b1;
                        if (n_ge19) begin
                            r_rate <= rate_ok ? head_rate[15:0] : ogpd_pkg::RATE_DEFAULT;
                        end
                    end else if (tags_hit) begin
                        r_tags <= 1'b1;
                    end
                end
            end

            if (i_cmd.err) begin
                r_mpend <= 1'b1;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
                if (r_bpend) begin
                    r_bpend <= 1'b0;
                end else begin
                    r_mpend <= 1'b0;
                end
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_data  = r_out;

endmodule

// ===== design/ogpd_ctrl.sv =====
`timescale 1ns / 1ps
module ogpd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ogpd_pkg::t_dp_stat i_stat,
    output ogpd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_FIND,
        S_HDR,
        S_LAC,
        S_RD,
        S_LD,
        S_DATA,
        S_SEG,
        S_FLUSH,
        S_DEAD
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   acc;

    always_comb begin
        o_in_ready = (r_state == S_FIND) || (r_state == S_HDR) || (r_state == S_LAC) ||
                     (r_state == S_DATA) || (r_state == S_DEAD);
        acc        = i_in_valid && o_in_ready;
        o_cmd         = '0;
        o_cmd.win_clr = r_state != S_FIND;
        n_state       = r_state;
        n_ret         = r_ret;
        case (r_state)
            S_FIND: begin
                if (acc) begin
                    o_cmd.find = 1'b1;
                    if (i_stat.sync_hit) begin
                        n_state = S_HDR;
                    end
                end
            end
            S_HDR: begin
                if (acc) begin
                    o_cmd.hdr = 1'b1;
                    if (i_stat.hdr_last) begin
                        if (i_stat.ver_bad) begin
                            o_cmd.err      = 1'b1;
                            o_cmd.err_code = ogpd_pkg::ERR_VERSION;
                            n_ret          = S_DEAD;
                            n_state        = S_FLUSH;
                        end else if (i_stat.byte_zero) begin
                            n_state = S_FIND;
                        end else begin
                            n_state = S_LAC;
                        end
                    end
                end
            end
            S_LAC: begin
                if (acc) begin
                    o_cmd.lac = 1'b1;
                    if (i_stat.lac_last) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                o_cmd.load = 1'b1;
                if (i_stat.rd_zero) begin
                    n_state = S_SEG;
                end else begin
                    n_ret   = S_DATA;
                    n_state = S_FLUSH;
                end
            end
            S_DATA: begin
                if (acc) begin
                    if (i_stat.overflow) begin
                        o_cmd.err      = 1'b1;
                        o_cmd.err_code = ogpd_pkg::ERR_OVERFLOW;
                        n_ret          = S_DEAD;
                        n_state        = S_FLUSH;
                    end else begin
                        o_cmd.data = 1'b1;
                        if (i_stat.left_one) begin
                            n_state = S_SEG;
                        end else begin
                            n_ret   = S_DATA;
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_SEG: begin
                // Close one segment; a pending byte waits until the step is known to end.
                o_cmd.seg = 1'b1;
                if (i_stat.will_err) begin
                    n_ret   = S_DEAD;
                    n_state = S_FLUSH;
                end else if (i_stat.pos_next_done) begin
                    n_ret   = S_FIND;
                    n_state = S_FLUSH;
                end else if (i_stat.will_mark) begin
                    n_ret   = S_RD;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                if (i_stat.pend_any) begin
                    o_cmd.push = i_stat.out_free;
                end else begin
                    n_state = r_ret;
                end
            end
            S_DEAD: begin
                // drop everything until reset
            end
            default: begin
                n_state = S_FIND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FIND;
            r_ret   <= S_FIND;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

// ===== design/ogg_opus_page_demuxer.sv =====
`timescale 1ns / 1ps
// Path: a payload byte is latched in the datapath, then pushed to the output register in
// the flush state; its packet marker, if any, follows it on the output.
// Header and lacing bytes are taken back to back; a payload byte is taken only once the one
// before it has been flushed, and a byte that closes a segment also waits for the next lacing
// entry, and each zero-length one behind it, to be read through its registered port. Output stalls add.
// Reset: synchronous, active low; hunts for a page again, flags and error cleared.
module ogg_opus_page_demuxer #(
    parameter int PACKET_BUF_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ogpd_in_if.sink           i_byte_ch,
    ogpd_out_if.source        o_res_ch
);

    ogpd_pkg::t_dp_cmd  cmd;
    ogpd_pkg::t_dp_stat stat;
    logic               in_ready;

    ogpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte_ch.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ogpd_datapath #(
        .PACKET_BUF_BYTES (PACKET_BUF_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_byte_ch.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_ch.valid),
        .o_res_data  (o_res_ch.data),
        .i_res_ready (o_res_ch.ready)
    );

    assign i_byte_ch.ready = in_ready;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int BUF_BYTES   = 4096;
    localparam int CYCLE_LIMIT = 900000;

    typedef enum logic [1:0] {PH_FIND, PH_HEADER, PH_LACING, PH_DATA} t_phase;

    logic i_clk;
    logic i_rst_n;

    ogpd_in_if  byte_ch();
    ogpd_out_if res_ch();

    ogg_opus_page_demuxer #(.PACKET_BUF_BYTES(BUF_BYTES)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte_ch(byte_ch.sink),
        .o_res_ch (res_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // demuxer state mirror
    t_phase      dm_phase;
    logic [23:0] dm_window;
    int unsigned dm_hdr_pos;
    int unsigned dm_seg_total;
    logic [7:0]  dm_lacing[256];
    int unsigned dm_seg_pos;
    int unsigned dm_seg_left;
    int unsigned dm_pkt_bytes;
    logic [7:0]  dm_prefix[ogpd_pkg::PREFIX_LEN];
    bit          dm_head_seen;
    bit          dm_tags_seen;
    logic [15:0] dm_rate;
    bit          dm_error;

    ogpd_pkg::t_out_item expected_results[$];
    ogpd_pkg::t_out_item step_results[$];
    logic [7:0]  stream_bytes[$];
    int          mismatches;
    int          cycle_count;
    bit          quiet_phase;
    bit          stim_done;
    bit          in_fire;
    int          src_idle;

    task automatic push_result(input logic [1:0] kind, input logic [7:0] b,
                               input int unsigned len, input int unsigned dur,
                               input logic [15:0] rate, input logic [2:0] code);
        ogpd_pkg::t_out_item r;
        r = '0;
        r.kind = kind;
        r.byte_out = b;
        r.packet_length = len[ogpd_pkg::PKT_LEN_W-1:0];
        r.duration_ms = dur[6:0];
        r.rate_hz = rate;
        r.error_code = code;
        step_results.push_back(r);
    endtask

    task automatic flag_error(input logic [2:0] code);
        dm_error = 1'b1;
        push_result(ogpd_pkg::KIND_ERROR, 8'd0, 0, 0, 16'd0, code);
    endtask

    function automatic int unsigned frame_ms(input int unsigned n);
        int unsigned cfg, fus, cnt, total;
        cfg = dm_prefix[0] >> 3;
        if (cfg < 12) fus = (cfg % 4 == 0) ? 10000 : (cfg % 4 == 1) ? 20000 :
                            (cfg % 4 == 2) ? 40000 : 60000;
        else if (cfg < 16) fus = (cfg & 1) ? 20000 : 10000;
        else fus = (cfg % 4 == 0) ? 2500 : (cfg % 4 == 1) ? 5000 :
                   (cfg % 4 == 2) ? 10000 : 20000;
        case (dm_prefix[0] & 3)
            0: cnt = 1;
            3: begin
                if (n < 2) return 0;
                cnt = dm_prefix[1] & 8'h3f;
            end
            default: cnt = 2;
        endcase
        total = fus * cnt;
        if (cnt == 0 || total > 120000 || total % 1000 != 0) return 0;
        return total / 1000;
    endfunction

    function automatic bit prefix_is(input logic [63:0] magic);
        for (int i = 0; i < 8; i++)
            if (dm_prefix[i] != magic[63 - 8*i -: 8]) return 0;
        return 1;
    endfunction

    task automatic close_packet(output bit ok);
        int unsigned n, r, d;
        n = dm_pkt_bytes;
        ok = 1;
        if (!dm_head_seen && n >= 8 && prefix_is(ogpd_pkg::HEAD_MAGIC)) begin
            dm_head_seen = 1;
            if (n < ogpd_pkg::PREFIX_LEN) begin
                flag_error(ogpd_pkg::ERR_SHORT);
                ok = 0;
                return;
            end
            r = {dm_prefix[15], dm_prefix[14], dm_prefix[13], dm_prefix[12]};
            if (r == 8000 || r == 12000 || r == 16000 || r == 24000 || r == 48000)
                dm_rate = r[15:0];
            else
                dm_rate = ogpd_pkg::RATE_DEFAULT;
            if (dm_prefix[9] != 8'd1) begin
                flag_error(ogpd_pkg::ERR_NOT_MONO);
                ok = 0;
                return;
            end
            push_result(ogpd_pkg::KIND_DISCARD, 8'd0, n, 0, 16'd0, ogpd_pkg::ERR_NONE);
        end else if (!dm_tags_seen && n >= 8 && prefix_is(ogpd_pkg::TAGS_MAGIC)) begin
            dm_tags_seen = 1;
            push_result(ogpd_pkg::KIND_DISCARD, 8'd0, n, 0, 16'd0, ogpd_pkg::ERR_NONE);
        end else if (dm_head_seen && dm_tags_seen) begin
            d = frame_ms(n);
            if (d == 0) begin
                flag_error(ogpd_pkg::ERR_DURATION);
                ok = 0;
                return;
            end
            push_result(ogpd_pkg::KIND_ACCEPT, 8'd0, n, d, dm_rate, ogpd_pkg::ERR_NONE);
        end else begin
            push_result(ogpd_pkg::KIND_DISCARD, 8'd0, n, 0, 16'd0, ogpd_pkg::ERR_NONE);
        end
    endtask

    task automatic finish_segments();
        bit ok;
        forever begin
            if (dm_lacing[dm_seg_pos[7:0]] != ogpd_pkg::LACE_FULL) begin
                if (dm_pkt_bytes > 0) begin
                    close_packet(ok);
                    if (!ok) return;
                end
                dm_pkt_bytes = 0;
            end
            dm_seg_pos++;
            if (dm_seg_pos >= dm_seg_total) begin
                dm_phase = PH_FIND;
                dm_window = '0;
                return;
            end
            dm_seg_left = dm_lacing[dm_seg_pos[7:0]];
            if (dm_seg_left != 0) return;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        step_results.delete();
        if (dm_error) return;
        case (dm_phase)
            PH_FIND: begin
                if (dm_window == ogpd_pkg::SYNC_PREFIX && b == ogpd_pkg::SYNC_LAST) begin
                    dm_window = '0;
                    dm_hdr_pos = 0;
                    dm_phase = PH_HEADER;
                end else begin
                    dm_window = {dm_window[15:0], b};
                end
            end
            PH_HEADER: begin
                if (dm_hdr_pos == 0) dm_seg_total = b;
                if (dm_hdr_pos >= ogpd_pkg::HDR_LAST_POS) begin
                    if (dm_seg_total != 0) begin
                        flag_error(ogpd_pkg::ERR_VERSION);
                    end else begin
                        dm_seg_total = b;
                        dm_seg_pos = 0;
                        dm_hdr_pos = 0;
                        if (b == 0) begin
                            dm_phase = PH_FIND;
                            dm_window = '0;
                        end else begin
                            dm_phase = PH_LACING;
                        end
                    end
                end else begin
                    dm_hdr_pos++;
                end
            end
            PH_LACING: begin
                dm_lacing[dm_seg_pos[7:0]] = b;
                dm_seg_pos++;
                if (dm_seg_pos >= dm_seg_total) begin
                    dm_phase = PH_DATA;
                    dm_seg_pos = 0;
                    dm_seg_left = dm_lacing[0];
                    if (dm_seg_left == 0) finish_segments();
                end
            end
            default: begin
                if (dm_pkt_bytes + dm_seg_left > BUF_BYTES) begin
                    flag_error(ogpd_pkg::ERR_OVERFLOW);
                end else begin
                    push_result(ogpd_pkg::KIND_BYTE, b, 0, 0, 16'd0, ogpd_pkg::ERR_NONE);
                    if (dm_pkt_bytes < ogpd_pkg::PREFIX_LEN) dm_prefix[dm_pkt_bytes] = b;
                    dm_pkt_bytes++;
                    if (dm_seg_left > 0) dm_seg_left--;
                    if (dm_seg_left == 0) finish_segments();
                end
            end
        endcase
        if (step_results.size() > 0) step_results[$].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    task automatic report_mismatch(input string what, input ogpd_pkg::t_out_item got,
                                   input ogpd_pkg::t_out_item want);
        mismatches++;
        $display("mismatch %s: got %h expected %h at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // stream builders
    task automatic add_page(input logic [7:0] version, input logic [7:0] lace[$],
                            input logic [7:0] body[$]);
        stream_bytes.push_back(8'h4f);
        stream_bytes.push_back(8'h67);
        stream_bytes.push_back(8'h67);
        stream_bytes.push_back(8'h53);
        stream_bytes.push_back(version);
        for (int i = 0; i < 21; i++) stream_bytes.push_back(8'($urandom));
        stream_bytes.push_back(8'(lace.size()));
        foreach (lace[i]) stream_bytes.push_back(lace[i]);
        foreach (body[i]) stream_bytes.push_back(body[i]);
    endtask

    // one page holding the given packets, each under 255 bytes
    task automatic add_packets_page(input logic [7:0] pkt_a[$], input logic [7:0] pkt_b[$]);
        logic [7:0] lace[$];
        logic [7:0] body[$];
        lace.push_back(8'(pkt_a.size()));
        foreach (pkt_a[i]) body.push_back(pkt_a[i]);
        if (pkt_b.size() > 0 || $urandom_range(0, 1)) begin
            lace.push_back(8'(pkt_b.size()));
            foreach (pkt_b[i]) body.push_back(pkt_b[i]);
        end
        add_page(8'd0, lace, body);
    endtask

    function automatic void make_head(ref logic [7:0] p[$], input int len,
                                      input logic [7:0] chans, input logic [31:0] rate);
        p.delete();
        for (int i = 0; i < 8; i++) p.push_back(ogpd_pkg::HEAD_MAGIC[63 - 8*i -: 8]);
        for (int i = 8; i < len; i++) p.push_back(8'($urandom));
        if (len > 9) p[9] = chans;
        if (len > 15) begin
            p[12] = rate[7:0];
            p[13] = rate[15:8];
            p[14] = rate[23:16];
            p[15] = rate[31:24];
        end
    endfunction

    function automatic void make_tags(ref logic [7:0] p[$], input int len);
        p.delete();
        for (int i = 0; i < 8; i++) p.push_back(ogpd_pkg::TAGS_MAGIC[63 - 8*i -: 8]);
        for (int i = 8; i < len; i++) p.push_back(8'($urandom));
    endfunction

    // audio packet; unless any_toc is set, its TOC is mostly valid
    function automatic void make_audio(ref logic [7:0] p[$], input int len, input bit any_toc);
        logic [7:0] toc;
        p.delete();
        for (int i = 0; i < len; i++) p.push_back(8'($urandom));
        if (!any_toc) begin
            toc = {5'($urandom_range(16, 31)), 1'($urandom), 2'($urandom_range(0, 2))};
            p[0] = toc;
        end
    endfunction

    task automatic add_stream_start(input logic [31:0] rate);
        logic [7:0] h[$];
        logic [7:0] t[$];
        logic [7:0] none[$];
        make_head(h, 19, 8'd1, rate);
        make_tags(t, $urandom_range(8, 40));
        add_packets_page(h, none);
        add_packets_page(t, none);
    endtask

    task automatic add_random_audio_pages(input int count, input bit any_toc);
        logic [7:0] a[$];
        logic [7:0] b[$];
        logic [7:0] lace[$];
        logic [7:0] body[$];
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                // packet spanning two pages through a full segment
                make_audio(a, 255 + $urandom_range(1, 20), any_toc);
                lace = {8'd255};
                body.delete();
                for (int i = 0; i < 255; i++) body.push_back(a[i]);
                add_page(8'd0, lace, body);
                lace = {8'(a.size() - 255), 8'd0};
                body.delete();
                for (int i = 255; i < a.size(); i++) body.push_back(a[i]);
                add_page(8'd0, lace, body);
            end else begin
                make_audio(a, $urandom_range(1, 12), any_toc);
                make_audio(b, $urandom_range(0, 6), any_toc);
                add_packets_page(a, b);
            end
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < $urandom_range(1, 6); i++)
                    stream_bytes.push_back(8'($urandom));
        end
    endtask

    // byte driver: advance only after a transfer seen at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || in_fire) begin
            if (src_idle > 0) begin
                src_idle--;
                byte_ch.valid <= 1'b0;
            end else if (stream_bytes.size() > 0) begin
                if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                    src_idle = $urandom_range(0, 15);
                    byte_ch.valid <= 1'b0;
                end else begin
                    byte_ch.valid <= 1'b1;
                    byte_ch.data.byte_in <= stream_bytes.pop_front();
                end
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    int sink_stall;
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            res_ch.ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            sink_stall = $urandom_range(0, 15);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ogpd_pkg::t_out_item got, want;
        in_fire = i_rst_n && byte_ch.valid && byte_ch.ready;
        if (i_rst_n) begin
            cycle_count++;
            if (in_fire) predict_byte(byte_ch.data.byte_in);
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected", got, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind) report_mismatch("kind", got, want);
                    if (got.byte_out != want.byte_out) report_mismatch("byte", got, want);
                    if (got.packet_length != want.packet_length)
                        report_mismatch("length", got, want);
                    if (got.duration_ms != want.duration_ms)
                        report_mismatch("duration", got, want);
                    if (got.rate_hz != want.rate_hz) report_mismatch("rate", got, want);
                    if (got.error_code != want.error_code)
                        report_mismatch("error code", got, want);
                    if (got.last != want.last) report_mismatch("last", got, want);
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // wait for the stream to drain and results to arrive, then reset is not repeated
    task automatic drain();
        while (stream_bytes.size() > 0 || byte_ch.valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] p[$];
        logic [7:0] none[$];
        logic [7:0] lace[$];
        logic [7:0] body[$];
        mismatches = 0;
        cycle_count = 0;
        quiet_phase = 0;
        sink_stall = 0;
        src_idle = 0;
        in_fire = 0;
        i_rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data = '0;
        res_ch.ready = 1'b0;
        dm_phase = PH_FIND;
        dm_window = '0;
        dm_hdr_pos = 0;
        dm_seg_total = 0;
        dm_seg_pos = 0;
        dm_seg_left = 0;
        dm_pkt_bytes = 0;
        dm_head_seen = 0;
        dm_tags_seen = 0;
        dm_rate = ogpd_pkg::RATE_DEFAULT;
        dm_error = 0;
        foreach (dm_lacing[i]) dm_lacing[i] = '0;
        foreach (dm_prefix[i]) dm_prefix[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: garbage, near-sync, empty page, early packet, zero-length runs
        stream_bytes = {8'h00, 8'hff, 8'h4f, 8'h67, 8'h67, 8'h00, 8'h4f, 8'h4f};
        add_page(8'd0, none, none);
        make_audio(p, 3, 1);
        lace = {8'd0, 8'd0, 8'd3, 8'd0, 8'd0};
        add_page(8'd0, lace, p);
        // head with an odd rate maps to the default, tags, then every TOC code
        make_head(p, 25, 8'd1, 32'd44100);
        add_packets_page(p, none);
        make_tags(p, 8);
        add_packets_page(p, none);
        for (int c = 0; c < 4; c++) begin
            make_audio(p, 3, 0);
            p[0] = {5'($urandom_range(0, 31)), 1'($urandom), 2'(c)};
            p[1] = {2'b11, 6'd1};
            add_packets_page(p, none);
        end
        lace = {8'd255, 8'd255, 8'd0};
        body.delete();
        make_audio(p, 510, 0);
        add_page(8'd0, lace, p);
        drain();

        // random part; bad TOCs end the stream with a duration error
        add_stream_start(32'd16000);
        add_random_audio_pages(8, 0);
        add_random_audio_pages(2, 1);
        drain();
        // after a sticky error only a fresh stream is not possible; keep feeding noise
        for (int i = 0; i < 40; i++) stream_bytes.push_back(8'($urandom));
        make_head(p, $urandom_range(8, 18), 8'd1, 32'd8000);
        add_packets_page(p, none);
        quiet_phase = 1;
        add_random_audio_pages(2, 1);
        drain();

        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
